[sv/fap_pkg.sv]
// ----------------------------------------------------------------------------
// fap_pkg
// Shared widths, constants, register codes and types of the fader pickup filter.
// ----------------------------------------------------------------------------
package fap_pkg;

	// Field widths of the sample and update items.
	localparam int FADER_IDX_W = 3;
	localparam int RAW_W       = 12;
	localparam int POS_W       = 7;
	localparam int CN_W        = 8;

	// Converter full scale and fader position full scale.
	localparam int ADC_FULL = 4095;
	localparam int POS_MAX  = 127;

	// Configuration port.
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = 2;

	localparam logic [REG_IDX_W-1:0] REG_SYNC_THR  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_NOISE_THR = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_CTRL_BASE = 2'd2;

	localparam logic [POS_W-1:0] SYNC_THR_RST  = 7'd10;
	localparam logic [POS_W-1:0] NOISE_THR_RST = 7'd1;
	localparam logic [POS_W-1:0] CTRL_BASE_RST = 7'd80;

	typedef struct packed {
		logic [POS_W-1:0] sync_thr;
		logic [POS_W-1:0] noise_thr;
		logic [POS_W-1:0] ctrl_base;
	} cfg_t;

	// Per-item control information carried down the pipeline.
	typedef struct packed {
		logic [FADER_IDX_W-1:0] fader;
		logic                   loading;
		logic [POS_W-1:0]       preset;
	} item_t;

endpackage

[sv/fap_if.sv]
// ----------------------------------------------------------------------------
// fap_in_if / fap_out_if
// Valid/ready channels for fader samples and controller updates.
// ----------------------------------------------------------------------------
interface fap_in_if import fap_pkg::*;;
	logic                   valid;
	logic                   ready;
	logic [FADER_IDX_W-1:0] fader_index;
	logic [RAW_W-1:0]       raw_sample;
	logic                   preset_loading;
	logic [POS_W-1:0]       preset_value;

	modport source (
		output valid, fader_index, raw_sample, preset_loading, preset_value,
		input  ready
	);
	modport sink (
		input  valid, fader_index, raw_sample, preset_loading, preset_value,
		output ready
	);
endinterface

interface fap_out_if import fap_pkg::*;;
	logic             valid;
	logic             ready;
	logic [CN_W-1:0]  controller_number;
	logic [POS_W-1:0] controller_value;

	modport source (
		output valid, controller_number, controller_value,
		input  ready
	);
	modport sink (
		input  valid, controller_number, controller_value,
		output ready
	);
endinterface

[sv/fap_ram.sv]
// ----------------------------------------------------------------------------
// fap_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module fap_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[sv/fap_cfg.sv]
// ----------------------------------------------------------------------------
// fap_cfg
// APB register bank: sync threshold, noise threshold and controller base.
// ----------------------------------------------------------------------------
module fap_cfg import fap_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	logic [POS_W-1:0]     sync_thr_q;
	logic [POS_W-1:0]     noise_thr_q;
	logic [POS_W-1:0]     ctrl_base_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[APB_ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_thr_q  <= SYNC_THR_RST;
			noise_thr_q <= NOISE_THR_RST;
			ctrl_base_q <= CTRL_BASE_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_SYNC_THR:  sync_thr_q  <= pwdata[POS_W-1:0];
				REG_NOISE_THR: noise_thr_q <= pwdata[POS_W-1:0];
				REG_CTRL_BASE: ctrl_base_q <= pwdata[POS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_SYNC_THR:  prdata = APB_DATA_W'(sync_thr_q);
			REG_NOISE_THR: prdata = APB_DATA_W'(noise_thr_q);
			REG_CTRL_BASE: prdata = APB_DATA_W'(ctrl_base_q);
			default:       prdata = '0;
		endcase
	end

	assign cfg.sync_thr  = sync_thr_q;
	assign cfg.noise_thr = noise_thr_q;
	assign cfg.ctrl_base = ctrl_base_q;

endmodule

[sv/fap_scale.sv]
// ----------------------------------------------------------------------------
// fap_scale
// Scales a 12-bit converter reading to a 0..127 fader position, truncated.
// ----------------------------------------------------------------------------
module fap_scale import fap_pkg::*; (
	input  logic [RAW_W-1:0] raw,
	output logic [POS_W-1:0] pos
);

	localparam int PROD_W = RAW_W + POS_W;
	localparam int REM_W  = RAW_W + 1;

	logic [PROD_W-1:0] prod;
	logic [POS_W-1:0]  quo0;
	logic [REM_W-1:0]  rem;

	// Dividing by 4096 undershoots a division by 4095 by at most one. The
	// remainder against 4095 is the low bits plus the estimate, so a single
	// compare fixes the quotient.
	assign prod = PROD_W'(raw) * PROD_W'(POS_MAX);
	assign quo0 = prod[PROD_W-1:RAW_W];
	assign rem  = REM_W'(prod[RAW_W-1:0]) + REM_W'(quo0);
	assign pos  = quo0 + POS_W'(rem >= REM_W'(ADC_FULL));

endmodule

[sv/fap_ring.sv]
// ----------------------------------------------------------------------------
// fap_ring
// Sample windows per fader: write slot, ring RAM and running sum of each ring.
// ----------------------------------------------------------------------------
module fap_ring import fap_pkg::*; #(
	parameter int FADER_COUNT = 8,
	parameter int WINDOW_LEN  = 20
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	fap_in_if.sink                                smp,
	input  logic                                  s2_ready,
	output logic                                  vld_s1,
	output item_t                                 item_s1,
	output logic [$clog2(WINDOW_LEN*POS_MAX+1)-1:0] new_sum
);

	localparam int SUMW  = $clog2(WINDOW_LEN*POS_MAX+1);
	localparam int SW    = WINDOW_LEN > 1 ? $clog2(WINDOW_LEN) : 1;
	localparam int FW    = FADER_COUNT > 1 ? $clog2(FADER_COUNT) : 1;
	localparam int DEPTH = FADER_COUNT * WINDOW_LEN;
	localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;

	logic [SW-1:0]    slot_q [FADER_COUNT];
	logic             wrap_q [FADER_COUNT];
	logic [SUMW-1:0]  sum_q  [FADER_COUNT];

	logic [FW-1:0]    f_in;
	logic             in_range;
	logic             accept;
	logic             s1_go;
	logic [SW-1:0]    cur_slot;
	logic             last_slot;
	logic [AW-1:0]    rd_addr;
	logic [POS_W-1:0] scaled;
	logic [POS_W-1:0] ram_rdata;
	logic [POS_W-1:0] old_smp;
	logic [FW-1:0]    f_s1;

	logic [POS_W-1:0] scaled_s1;
	logic [AW-1:0]    addr_s1;
	logic             oldv_s1;
	logic             fwd_s1;
	logic [POS_W-1:0] fwd_data_s1;

	fap_scale u_scale (
		.raw (smp.raw_sample),
		.pos (scaled)
	);

	assign f_in      = FW'(smp.fader_index);
	assign in_range  = int'(smp.fader_index) < FADER_COUNT;
	assign s1_go     = vld_s1 && s2_ready;
	assign smp.ready = !vld_s1 || s1_go;
	assign accept    = smp.valid && smp.ready;
	assign cur_slot  = slot_q[f_in];
	assign last_slot = cur_slot == SW'(WINDOW_LEN - 1);
	assign rd_addr   = AW'(int'(f_in) * WINDOW_LEN + int'(cur_slot));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FADER_COUNT; i++) begin
				slot_q[i] <= '0;
				wrap_q[i] <= 1'b0;
			end
		end else if (accept && in_range) begin
			slot_q[f_in] <= last_slot ? '0 : cur_slot + SW'(1);
			if (last_slot) begin
				wrap_q[f_in] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept && in_range) begin
			vld_s1 <= 1'b1;
		end else if (s1_go) begin
			vld_s1 <= 1'b0;
		end
	end

	// A ring entry holds data only once its slot has been passed; before the
	// first wrap the oldest sample of the window is zero.
	always_ff @(posedge clk) begin
		if (accept && in_range) begin
			item_s1.fader   <= smp.fader_index;
			item_s1.loading <= smp.preset_loading;
			item_s1.preset  <= smp.preset_value;
			scaled_s1       <= scaled;
			addr_s1         <= rd_addr;
			oldv_s1         <= wrap_q[f_in];
			fwd_s1          <= s1_go && (addr_s1 == rd_addr);
			fwd_data_s1     <= scaled_s1;
		end
	end

	fap_ram #(
		.WIDTH (POS_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (s1_go),
		.waddr (addr_s1),
		.wdata (scaled_s1),
		.re    (accept && in_range),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	assign old_smp = !oldv_s1 ? '0 : (fwd_s1 ? fwd_data_s1 : ram_rdata);
	assign f_s1    = FW'(item_s1.fader);
	assign new_sum = sum_q[f_s1] - SUMW'(old_smp) + SUMW'(scaled_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FADER_COUNT; i++) begin
				sum_q[i] <= '0;
			end
		end else if (s1_go) begin
			sum_q[f_s1] <= new_sum;
		end
	end

endmodule

[sv/fap_pickup.sv]
// ----------------------------------------------------------------------------
// fap_pickup
// Mean of the window, pickup and noise decisions, and the update register.
// ----------------------------------------------------------------------------
module fap_pickup import fap_pkg::*; #(
	parameter int FADER_COUNT = 8,
	parameter int WINDOW_LEN  = 20
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  cfg_t                                  cfg,
	input  logic                                  vld_s1,
	input  item_t                                 item_s1,
	input  logic [$clog2(WINDOW_LEN*POS_MAX+1)-1:0] new_sum,
	output logic                                  s2_ready,
	fap_out_if.source                             upd
);

	localparam int SUMW    = $clog2(WINDOW_LEN*POS_MAX+1);
	localparam int WLOG    = $clog2(WINDOW_LEN);
	localparam int RK      = SUMW + WLOG;
	localparam int RECIP_W = RK + 1;
	localparam int PROD_W  = SUMW + RECIP_W;
	localparam int FW      = FADER_COUNT > 1 ? $clog2(FADER_COUNT) : 1;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((1 << RK) + WINDOW_LEN - 1) / WINDOW_LEN);

	logic [POS_W-1:0] last_q [FADER_COUNT];
	logic             pk_q   [FADER_COUNT];

	logic             vld_s2;
	item_t            item_s2;
	logic [SUMW-1:0]  sum_s2;

	logic [PROD_W-1:0] prod;
	logic [POS_W-1:0]  mean;
	logic [POS_W-1:0]  last;
	logic [POS_W-1:0]  diff;
	logic [FW-1:0]     f_s2;
	logic              emit;
	logic              last_wr;
	logic [POS_W-1:0]  last_val;
	logic              pk_wr;
	logic              pk_val;
	logic              room;
	logic              s2_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (s2_ready) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_ready && vld_s1) begin
			item_s2 <= item_s1;
			sum_s2  <= new_sum;
		end
	end

	// Exact division by the window length via a rounded-up reciprocal.
	assign prod = PROD_W'(sum_s2) * PROD_W'(RECIP);
	assign mean = prod[RK +: POS_W];
	assign f_s2 = FW'(item_s2.fader);
	assign last = last_q[f_s2];
	assign diff = (mean > last) ? mean - last : last - mean;

	always_comb begin
		emit     = 1'b0;
		last_wr  = 1'b0;
		last_val = mean;
		pk_wr    = 1'b0;
		pk_val   = 1'b0;
		if (item_s2.loading) begin
			last_wr  = 1'b1;
			last_val = item_s2.preset;
			pk_wr    = 1'b1;
			pk_val   = 1'b0;
		end else if (pk_q[f_s2] || diff > cfg.sync_thr) begin
			// The step that picks the fader up may also report it.
			pk_wr  = 1'b1;
			pk_val = 1'b1;
			if (diff > cfg.noise_thr) begin
				emit    = 1'b1;
				last_wr = 1'b1;
			end
		end
	end

	assign room     = !upd.valid || upd.ready;
	assign s2_go    = vld_s2 && (room || !emit);
	assign s2_ready = !vld_s2 || s2_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FADER_COUNT; i++) begin
				last_q[i] <= '0;
				pk_q[i]   <= 1'b0;
			end
		end else if (s2_go) begin
			if (last_wr) begin
				last_q[f_s2] <= last_val;
			end
			if (pk_wr) begin
				pk_q[f_s2] <= pk_val;
			end
		end
	end

	logic             out_vld_q;
	logic [CN_W-1:0]  cn_q;
	logic [POS_W-1:0] cv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (s2_go && emit) begin
			out_vld_q <= 1'b1;
		end else if (upd.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_go && emit) begin
			cn_q <= CN_W'(cfg.ctrl_base) + CN_W'(item_s2.fader);
			cv_q <= mean;
		end
	end

	assign upd.valid             = out_vld_q;
	assign upd.controller_number = cn_q;
	assign upd.controller_value  = cv_q;

endmodule

[sv/fader_average_pickup_filter.sv]
// ----------------------------------------------------------------------------
// fader_average_pickup_filter
// Per-fader moving average with preset pickup and noise gating.
// ----------------------------------------------------------------------------
// The sample channel takes one converter reading per item, tagged with its
// fader. The reading is scaled to 0..127 and added to that fader's window of
// WINDOW_LEN samples; a running sum per fader gives the window mean. The update
// channel carries a controller number and value whenever a synced fader moves
// by more than the noise threshold. Samples with a fader index at or beyond
// FADER_COUNT are taken and dropped.
// One sample is taken every cycle while the sample channel is not stalled. An update
// is registered in the ring stage with its RAM read and sum update, the pickup
// stage with the mean and its decisions, then the update register.
// When the receiver holds ready low, empty pipeline stages still fill, and the
// sample channel stalls only once every stage holds an item.
// Reset clears all windows to zero, all faders to unsynced with last value
// zero, and loads the register defaults (sync 10, noise 1, base 80).
// Registers sit at byte addresses 0, 4 and 8 of the APB port.
// ----------------------------------------------------------------------------
module fader_average_pickup_filter import fap_pkg::*; #(
	parameter int FADER_COUNT = 8,
	parameter int WINDOW_LEN  = 20
) (
	input  logic                  clk,
	input  logic                  arst_n,
	fap_in_if.sink                sample,
	fap_out_if.source             update,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int SUMW = $clog2(WINDOW_LEN*POS_MAX+1);

	cfg_t            cfg;
	logic            vld_s1;
	item_t           item_s1;
	logic [SUMW-1:0] new_sum;
	logic            s2_ready;

	fap_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	fap_ring #(
		.FADER_COUNT (FADER_COUNT),
		.WINDOW_LEN  (WINDOW_LEN)
	) u_ring (
		.clk      (clk),
		.arst_n   (arst_n),
		.smp      (sample),
		.s2_ready (s2_ready),
		.vld_s1   (vld_s1),
		.item_s1  (item_s1),
		.new_sum  (new_sum)
	);

	fap_pickup #(
		.FADER_COUNT (FADER_COUNT),
		.WINDOW_LEN  (WINDOW_LEN)
	) u_pickup (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.vld_s1   (vld_s1),
		.item_s1  (item_s1),
		.new_sum  (new_sum),
		.s2_ready (s2_ready),
		.upd      (update)
	);

endmodule

[sv/fap_checker.sv]
// ----------------------------------------------------------------------------
// fap_checker
// Port-level checks of the fader pickup filter, bound to its top level.
// ----------------------------------------------------------------------------
module fap_checker import fap_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  sample_ready,
	input logic                  update_valid,
	input logic                  update_ready,
	input logic [CN_W-1:0]       controller_number,
	input logic [POS_W-1:0]      controller_value,
	input logic                  psel,
	input logic                  penable,
	input logic                  pwrite,
	input logic                  pready,
	input logic [APB_ADDR_W-1:0] paddr,
	input logic [APB_DATA_W-1:0] pwdata,
	input logic [APB_DATA_W-1:0] prdata
);

	logic                 reg_wr;
	logic [REG_IDX_W-1:0] reg_idx;

	assign reg_idx = paddr[APB_ADDR_W-1:2];
	assign reg_wr  = psel && penable && pwrite && pready &&
		(reg_idx == REG_SYNC_THR || reg_idx == REG_NOISE_THR ||
		 reg_idx == REG_CTRL_BASE);

	// With the update register empty nothing can back up into the sample side.
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!update_valid |-> sample_ready)
		else $error("sample channel stalled with the update register empty");

	// A waiting update keeps its payload.
	a_update_held: assert property (@(posedge clk) disable iff (!arst_n)
		update_valid && !update_ready |=>
			update_valid && $stable(controller_number) && $stable(controller_value))
		else $error("pending update changed before it was taken");

	// A register reads back what was just written to it.
	a_cfg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		reg_wr ##1 (psel && !pwrite && reg_idx == $past(reg_idx)) |->
			prdata == APB_DATA_W'($past(pwdata[POS_W-1:0])))
		else $error("register read back differs from the value written");

endmodule

bind fader_average_pickup_filter fap_checker u_fap_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.sample_ready      (sample.ready),
	.update_valid      (update.valid),
	.update_ready      (update.ready),
	.controller_number (update.controller_number),
	.controller_value  (update.controller_value),
	.psel              (psel),
	.penable           (penable),
	.pwrite            (pwrite),
	.pready            (pready),
	.paddr             (paddr),
	.pwdata            (pwdata),
	.prdata            (prdata)
);

[tb/tb_fader_average_pickup_filter.sv]
// ----------------------------------------------------------------------------
// tb_fader_average_pickup_filter
// Self-checking bench for the fader pickup filter with per-fader moving average.
// Samples go in with random gaps and updates come out under random back
// pressure. A scoreboard keeps its own windows, last values and sync flags for
// every fader, predicts each controller update, and compares every update
// field by field in order. The APB registers are rewritten between phases,
// only while the block is idle, with extreme and random settings.
// ----------------------------------------------------------------------------
module tb_fader_average_pickup_filter;
	import fap_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int FADERS          = 8;
	localparam int WINDOW          = 20;
	localparam int ITEMS_PER_PHASE = 136;
	localparam int PHASES          = 5;
	localparam int DRAIN_CYCLES    = 8;
	localparam int STALL_LIMIT     = 2000;

	typedef struct {
		logic [CN_W-1:0]  number;
		logic [POS_W-1:0] value;
	} update_t;

	class pickup_tracker;
		logic [POS_W-1:0] window [FADERS][WINDOW];
		int               slot [FADERS];
		logic [POS_W-1:0] last_value [FADERS];
		bit               synced [FADERS];
		cfg_t             cfg;
		update_t          pending_updates [$];
		int               mismatch_count;

		function new();
			foreach (window[i, j]) window[i][j] = '0;
			foreach (slot[i]) begin
				slot[i] = 0;
				last_value[i] = '0;
				synced[i] = 1'b0;
			end
			cfg.sync_thr = SYNC_THR_RST;
			cfg.noise_thr = NOISE_THR_RST;
			cfg.ctrl_base = CTRL_BASE_RST;
			mismatch_count = 0;
		endfunction

		task report_mismatch(string what);
			$display("ERROR %0t ns: %s", $time, what);
			mismatch_count++;
		endtask

		function void set_config(logic [REG_IDX_W-1:0] idx, logic [POS_W-1:0] value);
			case (idx)
				REG_SYNC_THR: cfg.sync_thr = value;
				REG_NOISE_THR: cfg.noise_thr = value;
				REG_CTRL_BASE: cfg.ctrl_base = value;
				default: ;
			endcase
		endfunction

		// Applies one accepted sample and queues the update it causes, if any.
		function void note_sample(logic [FADER_IDX_W-1:0] fader, logic [RAW_W-1:0] raw,
				logic loading, logic [POS_W-1:0] preset);
			int unsigned total;
			int unsigned mean;
			int unsigned delta;
			update_t     upd_item;
			window[fader][slot[fader]] = POS_W'((int'(raw) * POS_MAX) / ADC_FULL);
			slot[fader] = (slot[fader] + 1) % WINDOW;
			total = 0;
			for (int j = 0; j < WINDOW; j++) total += window[fader][j];
			mean = total / WINDOW;
			if (loading) begin
				synced[fader] = 1'b0;
				last_value[fader] = preset;
				return;
			end
			delta = (mean > last_value[fader]) ? mean - last_value[fader]
				: last_value[fader] - mean;
			if (!synced[fader]) begin
				if (delta > cfg.sync_thr) synced[fader] = 1'b1;
				else return;
			end
			if (delta > cfg.noise_thr) begin
				upd_item.number = CN_W'(int'(cfg.ctrl_base) + int'(fader));
				upd_item.value = POS_W'(mean);
				pending_updates.push_back(upd_item);
				last_value[fader] = POS_W'(mean);
			end
		endfunction

		task check_update(logic [CN_W-1:0] number, logic [POS_W-1:0] value);
			update_t want;
			if (pending_updates.size() == 0) begin
				report_mismatch($sformatf("unexpected update number %0d value %0d",
					number, value));
				return;
			end
			want = pending_updates.pop_front();
			if (number !== want.number)
				report_mismatch($sformatf("controller_number %0d, expected %0d",
					number, want.number));
			if (value !== want.value)
				report_mismatch($sformatf("controller_value %0d, expected %0d",
					value, want.value));
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	fap_in_if  smp ();
	fap_out_if upd ();

	pickup_tracker tracker = new();
	bit send_steady = 1'b0;
	bit recv_steady = 1'b0;
	int quiet_cycles = 0;

	fader_average_pickup_filter #(
		.FADER_COUNT(FADERS),
		.WINDOW_LEN (WINDOW)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (smp),
		.update (upd),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Ends the run if nothing moves on any port for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((smp.valid && smp.ready) || (upd.valid && upd.ready) || (psel && penable))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin : update_sink
		int stall;
		upd.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 39) == 0) recv_steady = !recv_steady;
			stall = recv_steady ? 0 : $urandom_range(0, 4);
			repeat (stall) begin
				@(negedge clk);
				upd.ready <= 1'b0;
			end
			@(negedge clk);
			upd.ready <= 1'b1;
			do @(posedge clk); while (!upd.valid);
			tracker.check_update(upd.controller_number, upd.controller_value);
		end
	end

	task automatic drive_sample(input int fader, input int raw, input bit loading,
			input int preset);
		int gap;
		if ($urandom_range(0, 39) == 0) send_steady = !send_steady;
		gap = send_steady ? 0 : $urandom_range(0, 4);
		repeat (gap) begin
			@(negedge clk);
			smp.valid <= 1'b0;
		end
		@(negedge clk);
		smp.valid <= 1'b1;
		smp.fader_index <= FADER_IDX_W'(fader);
		smp.raw_sample <= RAW_W'(raw);
		smp.preset_loading <= loading;
		smp.preset_value <= POS_W'(preset);
		do @(posedge clk); while (!smp.ready);
		tracker.note_sample(FADER_IDX_W'(fader), RAW_W'(raw), loading, POS_W'(preset));
	endtask

	// Stops the sample stream and waits until the block has nothing left in flight.
	task automatic settle();
		@(negedge clk);
		smp.valid <= 1'b0;
		while (tracker.pending_updates.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [REG_IDX_W-1:0] idx,
			input logic [POS_W-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= APB_DATA_W'(value);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		tracker.set_config(idx, value);
		// Read the register back right away.
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== APB_DATA_W'(value))
			tracker.report_mismatch($sformatf("register %0d reads %0d, expected %0d",
				idx, prdata, value));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic load_settings(input int sync_thr, input int noise_thr, input int base);
		settle();
		write_register(REG_SYNC_THR, POS_W'(sync_thr));
		write_register(REG_NOISE_THR, POS_W'(noise_thr));
		write_register(REG_CTRL_BASE, POS_W'(base));
	endtask

	initial begin : stimulus
		int target [FADERS];
		int focus;
		int fader;
		int pick;
		int raw;
		int jitter;
		smp.valid = 1'b0;
		smp.fader_index = '0;
		smp.raw_sample = '0;
		smp.preset_loading = 1'b0;
		smp.preset_value = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		foreach (target[i]) target[i] = $urandom_range(0, ADC_FULL);
		focus = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Two full-scale samples pick a fader up and emit in the same step.
		drive_sample(0, ADC_FULL, 1'b0, 0);
		drive_sample(0, ADC_FULL, 1'b0, 0);
		drive_sample(7, ADC_FULL, 1'b0, 127);
		drive_sample(7, ADC_FULL, 1'b0, 127);
		// A preset far from the fader makes the first real sample pick up.
		drive_sample(1, 0, 1'b1, 127);
		drive_sample(1, 0, 1'b0, 0);
		drive_sample(2, 4094, 1'b1, 0);
		drive_sample(2, 1, 1'b0, 0);
		drive_sample(2, 2048, 1'b0, 127);
		drive_sample(2, 1, 1'b0, 0);
		for (int i = 3; i <= 6; i++) begin
			drive_sample(i, ADC_FULL, 1'b0, 0);
			drive_sample(i, ADC_FULL, 1'b0, 0);
		end
		drive_sample(5, 2048, 1'b1, 7'h55);
		drive_sample(6, 1, 1'b1, 7'h2A);
		drive_sample(4, 12'hAAA, 1'b0, 7'h2A);
		drive_sample(4, 12'h555, 1'b0, 7'h55);

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				1: load_settings(0, 0, POS_MAX);
				2: load_settings(POS_MAX, POS_MAX, 0);
				3: load_settings($urandom_range(0, 20), $urandom_range(0, 4),
					$urandom_range(0, POS_MAX));
				4: load_settings(3, 2, 121);
				default: ;
			endcase
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// Most samples follow a fader that the user is moving.
				if ($urandom_range(0, 29) == 0) focus = $urandom_range(0, FADERS - 1);
				fader = ($urandom_range(0, 1) == 0) ? focus : $urandom_range(0, FADERS - 1);
				pick = $urandom_range(0, 99);
				if (pick < 10) begin
					case ($urandom_range(0, 3))
						0: target[fader] = 0;
						1: target[fader] = ADC_FULL;
						default: target[fader] = $urandom_range(0, ADC_FULL);
					endcase
				end
				jitter = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 60)) - 30;
				raw = target[fader] + jitter;
				if (raw < 0) raw = 0;
				if (raw > ADC_FULL) raw = ADC_FULL;
				if (pick >= 94)
					raw = $urandom_range(0, ADC_FULL);
				drive_sample(fader, raw, pick < 6, $urandom_range(0, POS_MAX));
			end
		end

		settle();
		if (tracker.mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
